/* rtl/normal_matrix_3x3_defines.svh */
// Assertion helpers, clocked on clk; the same-cycle one is masked by rst
`ifndef NORMAL_MATRIX_3X3_DEFINES_SVH
`define NORMAL_MATRIX_3X3_DEFINES_SVH

// same-cycle implication
`define NM3_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NM3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/nm3_pkg.sv */
`timescale 1ns / 1ps
package nm3_pkg;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int ENTRY_WIDTH_DEF = 24;

  // entries are indexed column * 3 + row
  localparam int NUM_ENTRIES = 9;

  typedef struct packed {
    logic zero;
  } det_flags_t;
endpackage

/* rtl/nm3_cof.sv */
`timescale 1ns / 1ps
module nm3_cof #(
  parameter int W = nm3_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [W-1:0]   a [nm3_pkg::NUM_ENTRIES],
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [2*W:0]   cof [nm3_pkg::NUM_ENTRIES],
  output logic signed [W-1:0]   a0 [3]
);
  import nm3_pkg::*;

  localparam int CW = 2 * W + 1;

  logic [1:0] vld, en;
  logic signed [2*W-1:0] p0 [NUM_ENTRIES];
  logic signed [2*W-1:0] p1 [NUM_ENTRIES];
  logic signed [W-1:0]   a0_s1 [3];

  assign en[1]    = ~vld[1] | out_ready;
  assign en[0]    = ~vld[0] | en[1];
  assign in_ready = en[0];
  assign out_valid = vld[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      if (en[1]) vld[1] <= vld[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p0[i*3+j] <= a[((i+1)%3)*3 + (j+1)%3] * a[((i+2)%3)*3 + (j+2)%3];
          p1[i*3+j] <= a[((i+1)%3)*3 + (j+2)%3] * a[((i+2)%3)*3 + (j+1)%3];
        end
        a0_s1[i] <= a[i];
      end
    end
    if (en[1]) begin
      for (int k = 0; k < NUM_ENTRIES; k++) begin
        cof[k] <= CW'(p0[k]) - CW'(p1[k]);
      end
      for (int i = 0; i < 3; i++) begin
        a0[i] <= a0_s1[i];
      end
    end
  end
endmodule

/* rtl/nm3_det.sv */
`timescale 1ns / 1ps
module nm3_det #(
  parameter int W = nm3_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [2*W:0]   cof [nm3_pkg::NUM_ENTRIES],
  input  logic signed [W-1:0]   a0 [3],
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [3*W+2:0]        dmag,
  output nm3_pkg::det_flags_t   flags,
  output logic [8:0]            cneg,
  output logic [2*W-1:0]        cmag [nm3_pkg::NUM_ENTRIES]
);
  import nm3_pkg::*;

  localparam int CW = 2 * W + 1;
  localparam int DW = 3 * W + 3;

  logic [3:0] vld, en;

  // stage 1: partial products, cofactor split into low W bits and signed top
  logic signed [2*W:0]   pl [3];
  logic signed [2*W:0]   ph [3];
  logic signed [CW-1:0]  cof_s1 [NUM_ENTRIES];
  // stage 2: per-term product
  logic signed [DW-1:0]  term [3];
  logic signed [CW-1:0]  cof_s2 [NUM_ENTRIES];
  // stage 3: determinant
  logic signed [DW-1:0]  det;
  logic signed [CW-1:0]  cof_s3 [NUM_ENTRIES];

  always_comb begin
    en[3] = ~vld[3] | out_ready;
    for (int s = 2; s >= 0; s--) begin
      en[s] = ~vld[s] | en[s+1];
    end
  end
  assign in_ready  = en[0];
  assign out_valid = vld[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int s = 1; s < 4; s++) begin
        if (en[s]) vld[s] <= vld[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int j = 0; j < 3; j++) begin
        pl[j] <= a0[j] * $signed({1'b0, cof[j][W-1:0]});
        ph[j] <= a0[j] * $signed(cof[j][CW-1:W]);
      end
      cof_s1 <= cof;
    end
    if (en[1]) begin
      for (int j = 0; j < 3; j++) begin
        term[j] <= (DW'(ph[j]) <<< W) + DW'(pl[j]);
      end
      cof_s2 <= cof_s1;
    end
    if (en[2]) begin
      det    <= term[0] + term[1] + term[2];
      cof_s3 <= cof_s2;
    end
    if (en[3]) begin
      flags.zero <= (det == '0);
      dmag       <= det[DW-1] ? DW'(-det) : DW'(det);
      for (int k = 0; k < NUM_ENTRIES; k++) begin
        cneg[k] <= cof_s3[k][CW-1] ^ det[DW-1];
        cmag[k] <= cof_s3[k][CW-1] ? (2*W)'(-cof_s3[k]) : (2*W)'(cof_s3[k]);
      end
    end
  end
endmodule

/* rtl/nm3_div.sv */
`timescale 1ns / 1ps
module nm3_div #(
  parameter int W = nm3_pkg::ENTRY_WIDTH_DEF,
  parameter int F = nm3_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [3*W+2:0]        dmag,
  input  nm3_pkg::det_flags_t   flags,
  input  logic [8:0]            cneg,
  input  logic [2*W-1:0]        cmag [nm3_pkg::NUM_ENTRIES],
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [W-1:0]   res [nm3_pkg::NUM_ENTRIES],
  output logic                  singular,
  output logic                  saturated
);
  import nm3_pkg::*;

  localparam int DW   = 3 * W + 3;
  localparam int RW   = 2 * W + 2 * F;
  localparam int CMPW = (RW > DW + W) ? RW : DW + W;
  localparam int NS   = W + 2;  // prescale, W quotient steps, clamp

  logic [NS-1:0] vld, en;

  logic [RW-1:0] rem  [0:W][NUM_ENTRIES];
  logic [W-1:0]  quo  [0:W][NUM_ENTRIES];
  logic [8:0]    ovf  [0:W];
  logic [8:0]    ng   [0:W];
  logic [DW-1:0] dv   [0:W];
  logic [W:0]    zr;

  logic [CMPW-1:0] dsh [1:W];
  logic [8:0]      take [1:W];

  always_comb begin
    en[NS-1] = ~vld[NS-1] | out_ready;
    for (int s = NS - 2; s >= 0; s--) begin
      en[s] = ~vld[s] | en[s+1];
    end
  end
  assign in_ready  = en[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int s = 1; s < NS; s++) begin
        if (en[s]) vld[s] <= vld[s-1];
      end
    end
  end

  // step s retires quotient bit W-s
  always_comb begin
    for (int s = 1; s <= W; s++) begin
      dsh[s] = CMPW'(dv[s-1]) << (W - s);
      for (int k = 0; k < NUM_ENTRIES; k++) begin
        take[s][k] = (CMPW'(rem[s-1][k]) >= dsh[s]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < NUM_ENTRIES; k++) begin
        rem[0][k] <= RW'(cmag[k]) << (2 * F);
        quo[0][k] <= '0;
        // quotient of 2^W or more can only clamp
        ovf[0][k] <= ((CMPW'(cmag[k]) << (2 * F)) >= (CMPW'(dmag) << W));
      end
      ng[0] <= cneg;
      dv[0] <= dmag;
      zr[0] <= flags.zero;
    end
    for (int s = 1; s <= W; s++) begin
      if (en[s]) begin
        for (int k = 0; k < NUM_ENTRIES; k++) begin
          rem[s][k] <= take[s][k] ? rem[s-1][k] - RW'(dsh[s]) : rem[s-1][k];
          quo[s][k] <= quo[s-1][k] | (W'(take[s][k]) << (W - s));
        end
        ovf[s] <= ovf[s-1];
        ng[s]  <= ng[s-1];
        dv[s]  <= dv[s-1];
        zr[s]  <= zr[s-1];
      end
    end
  end

  logic [W-1:0] lim  [NUM_ENTRIES];
  logic [W-1:0] mag  [NUM_ENTRIES];
  logic [8:0]   clip;

  always_comb begin
    for (int k = 0; k < NUM_ENTRIES; k++) begin
      lim[k]  = ng[W][k] ? (W'(1) << (W - 1)) : ((W'(1) << (W - 1)) - W'(1));
      clip[k] = ovf[W][k] | (quo[W][k] > lim[k]);
      mag[k]  = clip[k] ? lim[k] : quo[W][k];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      for (int k = 0; k < NUM_ENTRIES; k++) begin
        if (zr[W]) res[k] <= '0;
        else       res[k] <= ng[W][k] ? $signed(-mag[k]) : $signed(mag[k]);
      end
      singular  <= zr[W];
      saturated <= ~zr[W] & (|clip);
    end
  end
endmodule

/* rtl/normal_matrix_3x3.sv */
`timescale 1ns / 1ps
// Normal matrix (inverse transpose) of a 3x3 signed fixed-point matrix. Takes
// one matrix per cycle and gives one per cycle while out_ready stays high:
// a cofactor pipeline, a determinant and magnitude pipeline, then a restoring
// division pipeline of ENTRY_WIDTH + 2 stages (prescale, ENTRY_WIDTH steps of
// one quotient bit each for all nine entries, clamp).
// Quotients truncate toward zero and clamp to the entry range (saturated set);
// a zero determinant gives zero entries with singular set.
`include "normal_matrix_3x3_defines.svh"
module normal_matrix_3x3 #(
  parameter int FRAC_BITS   = nm3_pkg::FRAC_BITS_DEF,
  parameter int ENTRY_WIDTH = nm3_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [ENTRY_WIDTH-1:0] in_c0_r0,
  input  logic signed [ENTRY_WIDTH-1:0] in_c0_r1,
  input  logic signed [ENTRY_WIDTH-1:0] in_c0_r2,
  input  logic signed [ENTRY_WIDTH-1:0] in_c1_r0,
  input  logic signed [ENTRY_WIDTH-1:0] in_c1_r1,
  input  logic signed [ENTRY_WIDTH-1:0] in_c1_r2,
  input  logic signed [ENTRY_WIDTH-1:0] in_c2_r0,
  input  logic signed [ENTRY_WIDTH-1:0] in_c2_r1,
  input  logic signed [ENTRY_WIDTH-1:0] in_c2_r2,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [ENTRY_WIDTH-1:0] out_c0_r0,
  output logic signed [ENTRY_WIDTH-1:0] out_c0_r1,
  output logic signed [ENTRY_WIDTH-1:0] out_c0_r2,
  output logic signed [ENTRY_WIDTH-1:0] out_c1_r0,
  output logic signed [ENTRY_WIDTH-1:0] out_c1_r1,
  output logic signed [ENTRY_WIDTH-1:0] out_c1_r2,
  output logic signed [ENTRY_WIDTH-1:0] out_c2_r0,
  output logic signed [ENTRY_WIDTH-1:0] out_c2_r1,
  output logic signed [ENTRY_WIDTH-1:0] out_c2_r2,
  output logic                          singular,
  output logic                          saturated
);
  import nm3_pkg::*;

  localparam int W = ENTRY_WIDTH;

  logic signed [W-1:0] a [NUM_ENTRIES];
  logic signed [W-1:0] res [NUM_ENTRIES];

  assign a[0] = in_c0_r0;
  assign a[1] = in_c0_r1;
  assign a[2] = in_c0_r2;
  assign a[3] = in_c1_r0;
  assign a[4] = in_c1_r1;
  assign a[5] = in_c1_r2;
  assign a[6] = in_c2_r0;
  assign a[7] = in_c2_r1;
  assign a[8] = in_c2_r2;

  assign out_c0_r0 = res[0];
  assign out_c0_r1 = res[1];
  assign out_c0_r2 = res[2];
  assign out_c1_r0 = res[3];
  assign out_c1_r1 = res[4];
  assign out_c1_r2 = res[5];
  assign out_c2_r0 = res[6];
  assign out_c2_r1 = res[7];
  assign out_c2_r2 = res[8];

  logic                  cof_valid, cof_ready;
  logic signed [2*W:0]   cof [NUM_ENTRIES];
  logic signed [W-1:0]   a0 [3];

  logic                  det_valid, det_ready;
  logic [3*W+2:0]        dmag;
  det_flags_t            flags;
  logic [8:0]            cneg;
  logic [2*W-1:0]        cmag [NUM_ENTRIES];

  nm3_cof #(.W(W)) u_cof (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .a         (a),
    .out_valid (cof_valid),
    .out_ready (cof_ready),
    .cof       (cof),
    .a0        (a0)
  );

  nm3_det #(.W(W)) u_det (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cof_valid),
    .in_ready  (cof_ready),
    .cof       (cof),
    .a0        (a0),
    .out_valid (det_valid),
    .out_ready (det_ready),
    .dmag      (dmag),
    .flags     (flags),
    .cneg      (cneg),
    .cmag      (cmag)
  );

  nm3_div #(.W(W), .F(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (det_valid),
    .in_ready  (det_ready),
    .dmag      (dmag),
    .flags     (flags),
    .cneg      (cneg),
    .cmag      (cmag),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res),
    .singular  (singular),
    .saturated (saturated)
  );

  `NM3_ASSERT_NOW(a_singular_zero, out_valid && singular, !saturated && out_c0_r0 == '0 && out_c1_r1 == '0 && out_c2_r2 == '0, "singular result not cleared")
  `NM3_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "request refused with empty output")
  `NM3_ASSERT_NEXT(a_reset_empty, rst, !out_valid, "output valid after reset")
endmodule
